/* rtl/core/usf_pkg.sv */
// Shared types, constants and helpers for the UTF-16 substring finder.
// No dependencies; imported by every module of the block.
package usf_pkg;

  // Sizes of the needle store and of the haystack index.
  localparam int NEEDLE_MAX   = 32;
  localparam int HAYSTACK_MAX = 32768;
  localparam int CHAR_W       = 16;
  localparam int IDX_W        = $clog2(NEEDLE_MAX);
  localparam int LEN_W        = $clog2(NEEDLE_MAX + 1);
  localparam int POS_W        = $clog2(HAYSTACK_MAX + 1);
  localparam int START_W      = $clog2(HAYSTACK_MAX);

  // Input opcodes.
  localparam logic OP_NEEDLE   = 1'b0;
  localparam logic OP_HAYSTACK = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_NOT_FOUND = 2'd0,
    ST_FOUND     = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_t;

  // One result item.
  typedef struct packed {
    status_t              status;
    logic [START_W-1:0]   match_start;
  } usf_res_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic              fold_en;
    logic [CHAR_W-1:0] hay_char;
    logic              step;
    logic              clear;
  } usf_cell_ctl_t;

  // ASCII lower case to upper case when folding is enabled.
  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                  input logic en);
    logic [CHAR_W-1:0] r;
    r = c;
    if (en && c >= CHAR_W'(16'h0061) && c <= CHAR_W'(16'h007A)) begin
      r = c - CHAR_W'(16'h0020);
    end
    return r;
  endfunction

endpackage

/* rtl/core/usf_cell.sv */
// One needle position: stores a needle character and its partial-match bit.
// Depends on usf_pkg for the control struct and the case fold.
module usf_cell
  import usf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  usf_cell_ctl_t     ctl,
  input  logic              wr_en,
  input  logic [CHAR_W-1:0] wr_char,
  input  logic              active,
  input  logic              prev_bit,
  output logic              hit_nxt,
  output logic              bit_r
);

  logic [CHAR_W-1:0] char_r;
  logic              bit_nxt;

  // A match through this position extends the neighbor's partial match.
  assign hit_nxt = prev_bit && active &&
                   (fold_char(char_r, ctl.fold_en) == fold_char(ctl.hay_char, ctl.fold_en));

  always_comb begin
    bit_nxt = bit_r;
    if (ctl.clear) begin
      bit_nxt = 1'b0;
    end else if (ctl.step) begin
      bit_nxt = hit_nxt;
    end
  end

  // Partial-match bit is control state; the stored character is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b0;
    end else begin
      bit_r <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      char_r <= wr_char;
    end
  end

endmodule

/* rtl/core/usf_out_buf.sv */
// Two-entry result buffer: an output register plus a skid register.
// Depends on usf_pkg for the result struct.
module usf_out_buf
  import usf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  usf_res_t push_data,
  output logic     full,
  output logic     out_valid,
  input  logic     out_stall,
  output usf_res_t out_data
);

  logic     head_valid_r, head_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  usf_res_t head_r, head_nxt;
  usf_res_t skid_r, skid_nxt;
  logic     head_free;

  // The head may be loaded when it is empty or being taken this cycle.
  assign head_free = !head_valid_r || !out_stall;

  always_comb begin
    head_valid_nxt = head_valid_r;
    skid_valid_nxt = skid_valid_r;
    head_nxt       = head_r;
    skid_nxt       = skid_r;
    if (head_free) begin
      if (skid_valid_r) begin
        head_valid_nxt = 1'b1;
        head_nxt       = skid_r;
        skid_valid_nxt = push;
        skid_nxt       = push_data;
      end else begin
        head_valid_nxt = push;
        head_nxt       = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = head_valid_r;
  assign out_data  = head_r;

  // The skid entry is only ever occupied behind a waiting head entry.
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> head_valid_r)
    else $error("skid entry valid without a head entry");

  // A push is never offered while both entries are occupied.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("result pushed into a full buffer");

  // A stalled head entry stays put.
  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid_r && out_stall) |=> (head_valid_r && $stable(head_r)))
    else $error("stalled result changed");

endmodule

/* rtl/core/utf16_substring_finder.sv */
// Top level of the UTF-16 substring finder: control, a chain of needle cells
// and the result buffer. Depends on usf_pkg, usf_cell and usf_out_buf.
//
// Usage:
//   Needle characters (in_opcode 0) are loaded first; in_last closes the needle.
//   Haystack items (in_opcode 1) then stream in, one per cycle unless stalled.
//   Each needle position is a cell holding its character and a partial-match
//   bit; every searched haystack item advances all bits one cell down the chain.
//   The first completed match gives one result item with status found and the
//   start index; a haystack that ends without one gives not found, or needle
//   too long when the needle overflowed the 32-entry store.
//   Throughput is one item per cycle while in_stall is low. A result is
//   registered on the out_ channel when the item that causes it is accepted,
//   unless another is still stalled there; it then waits in the skid register.
//   cfg_we writes cfg_wdata into the case-insensitive mode bit; write it only
//   while the block is idle.
//   After reset the needle is empty and closed and the mode bit is clear.
//   The result channel has an output register and a skid register; in_stall
//   rises only when both hold results that the receiver has not taken.
module utf16_substring_finder
  import usf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [START_W-1:0] out_match_start
);

  logic               case_insensitive_r;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               too_long_r, too_long_nxt;
  logic               closed_r, closed_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               given_r, given_nxt;

  logic               acc;
  logic               buf_full;
  logic               hay_acc;
  logic               do_match;
  logic               found;
  logic               clear_hay;
  logic               clear_vec;
  logic [LEN_W-1:0]   eff_len;
  logic [IDX_W-1:0]   last_idx;
  logic [NEEDLE_MAX-1:0] wr_en;
  logic [NEEDLE_MAX-1:0] active;
  logic [NEEDLE_MAX-1:0] hit_nxt;
  logic [NEEDLE_MAX-1:0] bit_r;
  logic [NEEDLE_MAX-1:0] prev_bit;
  usf_cell_ctl_t      ctl;
  logic               res_push;
  usf_res_t           res;
  usf_res_t           out_data;

  assign acc      = in_valid && !in_stall;
  assign in_stall = buf_full;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_insensitive_r <= 1'b0;
    end else if (cfg_we) begin
      case_insensitive_r <= cfg_wdata;
    end
  end

  // Haystack step decode.
  assign hay_acc  = acc && (in_opcode == OP_HAYSTACK) && closed_r;
  assign do_match = hay_acc && !given_r && !too_long_r && (len_r != '0) &&
                    (pos_r < POS_W'(HAYSTACK_MAX));
  assign last_idx = IDX_W'(len_r - LEN_W'(1));
  assign found    = do_match && hit_nxt[last_idx];

  // A new needle, or the end of a haystack, clears haystack progress.
  assign clear_hay = (acc && (in_opcode == OP_NEEDLE) && closed_r) ||
                     (hay_acc && in_last);
  assign clear_vec = clear_hay ||
                     (hay_acc && !do_match && (pos_r >= POS_W'(HAYSTACK_MAX)));

  // Needle load: the length restarts when a closed needle is reopened.
  assign eff_len = closed_r ? '0 : len_r;

  always_comb begin
    len_nxt      = len_r;
    too_long_nxt = too_long_r;
    closed_nxt   = closed_r;
    pos_nxt      = pos_r;
    given_nxt    = given_r;
    wr_en        = '0;
    if (acc && (in_opcode == OP_NEEDLE)) begin
      too_long_nxt = closed_r ? 1'b0 : too_long_r;
      if (eff_len < LEN_W'(NEEDLE_MAX)) begin
        wr_en[IDX_W'(eff_len)] = 1'b1;
        len_nxt = eff_len + LEN_W'(1);
      end else begin
        len_nxt      = eff_len;
        too_long_nxt = 1'b1;
      end
      closed_nxt = in_last;
    end else if (hay_acc) begin
      if (pos_r < POS_W'(HAYSTACK_MAX)) begin
        pos_nxt = pos_r + POS_W'(1);
      end
      if (found) begin
        given_nxt = 1'b1;
      end
    end
    if (clear_hay) begin
      pos_nxt   = '0;
      given_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      too_long_r <= 1'b0;
      closed_r   <= 1'b1;
      pos_r      <= '0;
      given_r    <= 1'b0;
    end else begin
      len_r      <= len_nxt;
      too_long_r <= too_long_nxt;
      closed_r   <= closed_nxt;
      pos_r      <= pos_nxt;
      given_r    <= given_nxt;
    end
  end

  // Broadcast control and the chain of needle cells.
  assign ctl.fold_en  = case_insensitive_r;
  assign ctl.hay_char = in_char_code;
  assign ctl.step     = do_match;
  assign ctl.clear    = clear_vec;

  for (genvar i = 0; i < NEEDLE_MAX; i++) begin : g_cell
    assign active[i] = LEN_W'(i) < len_r;
    if (i == 0) begin : g_head
      assign prev_bit[i] = 1'b1;
    end else begin : g_body
      assign prev_bit[i] = bit_r[i-1];
    end
    usf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wr_en    (wr_en[i]),
      .wr_char  (in_char_code),
      .active   (active[i]),
      .prev_bit (prev_bit[i]),
      .hit_nxt  (hit_nxt[i]),
      .bit_r    (bit_r[i])
    );
  end

  // Result item formation.
  always_comb begin
    res_push          = 1'b0;
    res.status        = ST_NOT_FOUND;
    res.match_start   = '0;
    if (found) begin
      res_push        = 1'b1;
      res.status      = ST_FOUND;
      res.match_start = START_W'(pos_r[START_W-1:0] + START_W'(1) - START_W'(len_r));
    end else if (hay_acc && in_last && !given_r) begin
      res_push        = 1'b1;
      res.status      = too_long_r ? ST_TOO_LONG : ST_NOT_FOUND;
    end
  end

  usf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_status      = out_data.status;
  assign out_match_start = out_data.match_start;

  // The needle length never exceeds the store.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(NEEDLE_MAX))
    else $error("needle length beyond store size");

  // An overflowed needle always fills the store.
  a_too_long_full: assert property (@(posedge clk) disable iff (!rst_n)
    too_long_r |-> (len_r == LEN_W'(NEEDLE_MAX)))
    else $error("too-long flag set with a partial store");

  // No partial match lives beyond the needle length.
  a_vec_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (bit_r & ~active) == '0)
    else $error("partial match bit beyond needle length");

  // Once a result is given, the haystack yields no second found result.
  a_single_found: assert property (@(posedge clk) disable iff (!rst_n)
    given_r |-> !found)
    else $error("second match reported in one haystack");

endmodule

/* sim/utf16_substring_finder_tb.sv */
// Self-checking testbench for utf16_substring_finder: a directed table, then random searches.
// Every result is checked against an in-bench model of the search or a pinned table row.
// Depends on usf_pkg and the utf16_substring_finder RTL.
module utf16_substring_finder_tb;
  import usf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam usf_res_t    NO_TYPED    = '0;

  // One row of the directed table; the item repeats reps times, last only on the final one.
  typedef struct {
    logic               op;
    logic [CHAR_W-1:0]  ch;
    int unsigned        reps;
    logic               last;
    bit                 pinned;
    status_t            st;
    logic [START_W-1:0] start;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_opcode = OP_NEEDLE;
  logic [CHAR_W-1:0]  in_char_code = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic [START_W-1:0] out_match_start;

  // Model state of the search.
  logic                  case_fold;
  logic [CHAR_W-1:0]     needle_chars [NEEDLE_MAX];
  int unsigned           needle_len;
  bit                    needle_over;
  bit                    needle_done;
  logic [NEEDLE_MAX-1:0] match_vec;
  int unsigned           hay_pos;
  bit                    answered;

  // Results the block still owes, oldest first.
  usf_res_t pending_results [$];
  stim_row_t dir_rows [$];

  // Needle most recently loaded by the random generator, for planting copies.
  logic [CHAR_W-1:0] cur_needle [NEEDLE_MAX];
  int unsigned       cur_len;

  int unsigned err_count;
  int unsigned useful_items;
  int unsigned random_items;
  int unsigned found_count;
  int unsigned miss_count;
  int unsigned overlong_count;
  int unsigned mode_writes;
  int unsigned gap_pct;
  int unsigned rx_pct;
  bit          hold_req;
  int unsigned stall_left;
  int unsigned idle_cycles;

  utf16_substring_finder u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_char_code    (in_char_code),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_match_start (out_match_start)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ASCII lower case letters map to upper case when folding is on.
  function automatic logic [CHAR_W-1:0] ascii_upper(input logic [CHAR_W-1:0] c);
    if (case_fold && c >= 16'h0061 && c <= 16'h007A) begin
      return {c[15:6], 1'b0, c[4:0]};
    end
    return c;
  endfunction

  function automatic void clear_progress();
    match_vec = '0;
    hay_pos = 0;
    answered = 0;
  endfunction

  function automatic void reset_search();
    case_fold = 1'b0;
    for (int i = 0; i < NEEDLE_MAX; i++) needle_chars[i] = '0;
    needle_len = 0;
    needle_over = 0;
    needle_done = 1;
    clear_progress();
  endfunction

  // Advances the search by one item; returns 1 when the item produces a result.
  function automatic bit search_step(input logic op, input logic [CHAR_W-1:0] ch,
                                     input logic last, output usf_res_t res);
    int unsigned           pos;
    logic [NEEDLE_MAX-1:0] hits;
    logic [CHAR_W-1:0]     fc;
    bit                    found;
    bit                    given;
    res.status = ST_NOT_FOUND;
    res.match_start = '0;
    if (op == OP_NEEDLE) begin
      // A needle character after a closed needle starts a fresh one.
      if (needle_done) begin
        needle_len = 0;
        needle_over = 0;
        needle_done = 0;
        clear_progress();
      end
      if (needle_len < NEEDLE_MAX) begin
        needle_chars[needle_len] = ch;
        needle_len++;
      end else begin
        needle_over = 1;
      end
      if (last) needle_done = 1;
      return 0;
    end
    if (!needle_done) return 0;

    pos = hay_pos;
    if (hay_pos < HAYSTACK_MAX) hay_pos++;
    found = 0;
    if (!answered && !needle_over && needle_len > 0 && pos < HAYSTACK_MAX) begin
      // Compare against every stored position at once and advance the partial matches.
      hits = '0;
      fc = ascii_upper(ch);
      for (int i = 0; i < needle_len; i++) begin
        if (ascii_upper(needle_chars[i]) == fc) hits[i] = 1'b1;
      end
      match_vec = ((match_vec << 1) | 1) & hits;
      if (match_vec[needle_len-1]) begin
        found = 1;
        res.status = ST_FOUND;
        res.match_start = START_W'(pos + 1 - needle_len);
      end
    end else if (pos >= HAYSTACK_MAX) begin
      match_vec = '0;
    end

    if (found) begin
      answered = 1;
      if (last) clear_progress();
      return 1;
    end
    if (last) begin
      given = answered;
      clear_progress();
      if (given) return 0;
      res.status = needle_over ? ST_TOO_LONG : ST_NOT_FOUND;
      return 1;
    end
    return 0;
  endfunction

  // Idle lengths: mostly short, now and then a long stretch.
  function automatic int unsigned gap_len();
    if ($urandom_range(99) < 85) return $urandom_range(3, 1);
    return $urandom_range(30, 10);
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 40) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Offers one item, waits for it to be taken, then records what it should produce.
  task automatic offer_item(input logic op, input logic [CHAR_W-1:0] ch, input logic last,
                            input bit pinned, input usf_res_t typed);
    usf_res_t res;
    bit       ignored;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_char_code <= ch;
    in_last <= last;
    do @(posedge clk); while (in_stall);
    ignored = (op == OP_HAYSTACK) && !needle_done;
    if (!ignored) useful_items++;
    if (search_step(op, ch, last, res)) pending_results.push_back(pinned ? typed : res);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every expected result has arrived.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_case_fold(input logic v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case_fold = v;
    mode_writes++;
  endtask

  task automatic add_row(input logic op, input logic [CHAR_W-1:0] ch, input int unsigned reps,
                         input logic last, input bit pinned, input status_t st,
                         input int unsigned start);
    stim_row_t r;
    r.op = op;
    r.ch = ch;
    r.reps = reps;
    r.last = last;
    r.pinned = pinned;
    r.st = st;
    r.start = START_W'(start);
    dir_rows.push_back(r);
  endtask

  // Characters biased toward letters and the edges of the folding range.
  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) begin
      case ($urandom_range(3))
        0: return 16'h0041;
        1: return 16'h0042;
        2: return 16'h0061;
        default: return 16'h0062;
      endcase
    end
    if (r < 75) begin
      case ($urandom_range(5))
        0: return 16'h0040;
        1: return 16'h005A;
        2: return 16'h005B;
        3: return 16'h0060;
        4: return 16'h007A;
        default: return 16'h007B;
      endcase
    end
    return CHAR_W'($urandom);
  endfunction

  function automatic int unsigned pick_needle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(3, 1);
    if (r < 90) return $urandom_range(12, 4);
    if (r < 97) return $urandom_range(NEEDLE_MAX, 13);
    return $urandom_range(NEEDLE_MAX + 4, NEEDLE_MAX + 1);
  endfunction

  // One random search: mostly a needle and a haystack, sometimes raw noise.
  task automatic random_search();
    logic [CHAR_W-1:0] hay [$];
    logic [CHAR_W-1:0] c;
    int unsigned       nlen;
    int unsigned       hlen;
    int unsigned       at;
    bit                abandon;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(3, 1)) begin
        offer_item(logic'($urandom_range(1)), CHAR_W'($urandom), logic'($urandom_range(1)),
                   0, NO_TYPED);
      end
      return;
    end

    // Load a new needle unless the current one is reused.
    if (!needle_done || cur_len == 0 || $urandom_range(99) < 70) begin
      nlen = pick_needle_len();
      for (int k = 0; k < nlen; k++) begin
        c = pick_char();
        if (k < NEEDLE_MAX) cur_needle[k] = c;
        offer_item(OP_NEEDLE, c, k == nlen - 1, 0, NO_TYPED);
      end
      cur_len = (nlen > NEEDLE_MAX) ? NEEDLE_MAX : nlen;
    end

    // Haystack, often with a copy of the needle planted, letters case-flipped at random.
    hlen = ($urandom_range(99) < 85) ? $urandom_range(16, 1) : $urandom_range(60, 17);
    for (int k = 0; k < hlen; k++) hay.push_back(pick_char());
    if ($urandom_range(99) < 55 && cur_len <= hlen) begin
      at = $urandom_range(hlen - cur_len);
      for (int k = 0; k < cur_len; k++) begin
        c = cur_needle[k];
        if ((c | 16'h0020) >= 16'h0061 && (c | 16'h0020) <= 16'h007A && $urandom_range(1))
          c = c ^ 16'h0020;
        hay[at + k] = c;
      end
    end
    abandon = ($urandom_range(99) < 8);
    for (int k = 0; k < hlen; k++) begin
      offer_item(OP_HAYSTACK, hay[k], (k == hlen - 1) && !abandon, 0, NO_TYPED);
    end
  endtask

  // Holds the receiver off while single-character matches pile up behind it.
  task automatic overfill_results();
    settle();
    gap_pct = 0;
    hold_req = 1;
    offer_item(OP_NEEDLE, 16'h0041, 1'b1, 0, NO_TYPED);
    repeat (12) offer_item(OP_HAYSTACK, 16'h0041, 1'b1, 0, NO_TYPED);
    settle();
  endtask

  // Result side: checks each taken item, then decides the stall for the next cycle.
  always @(posedge clk) begin
    usf_res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d start %0d",
                                    out_status, out_match_start));
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_match_start !== want.match_start)
            report_mismatch($sformatf("match_start %0d, expected %0d",
                                      out_match_start, want.match_start));
          case (want.status)
            ST_FOUND: found_count++;
            ST_TOO_LONG: overlong_count++;
            default: miss_count++;
          endcase
        end
      end
      if (hold_req) begin
        hold_req = 0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && rx_pct != 0 && $urandom_range(99) < rx_pct) begin
        stall_left = gap_len();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too many cycles without any item moving on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("utf16_substring_finder verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned target;
    reset_search();
    cur_len = 0;
    err_count = 0;
    useful_items = 0;
    random_items = 0;
    found_count = 0;
    miss_count = 0;
    overlong_count = 0;
    mode_writes = 0;
    gap_pct = 10;
    rx_pct = 20;
    hold_req = 0;
    idle_cycles = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_case_fold(1'b0);

    // Directed table.
    // Empty needle after reset.
    add_row(OP_HAYSTACK, 16'h0078, 1, 1, 1, ST_NOT_FOUND, 0);
    // Extreme characters in needle and haystack.
    add_row(OP_NEEDLE, 16'h0000, 1, 0, 0, ST_NOT_FOUND, 0);
    add_row(OP_NEEDLE, 16'hFFFF, 1, 1, 0, ST_NOT_FOUND, 0);
    add_row(OP_HAYSTACK, 16'h0000, 2, 0, 0, ST_NOT_FOUND, 0);
    add_row(OP_HAYSTACK, 16'hFFFF, 1, 1, 1, ST_FOUND, 1);
    // Haystack while the needle is still open is ignored.
    add_row(OP_NEEDLE, 16'h0061, 1, 0, 0, ST_NOT_FOUND, 0);
    add_row(OP_HAYSTACK, 16'h0071, 1, 1, 0, ST_NOT_FOUND, 0);
    add_row(OP_NEEDLE, 16'h0062, 1, 1, 0, ST_NOT_FOUND, 0);
    // Overlapping candidate, then the rest of the haystack stays silent.
    add_row(OP_HAYSTACK, 16'h0061, 2, 0, 0, ST_NOT_FOUND, 0);
    add_row(OP_HAYSTACK, 16'h0062, 1, 0, 1, ST_FOUND, 1);
    add_row(OP_HAYSTACK, 16'h0078, 1, 1, 0, ST_NOT_FOUND, 0);
    // Needle longer than the haystack.
    add_row(OP_HAYSTACK, 16'h0061, 1, 1, 1, ST_NOT_FOUND, 0);
    // A new needle drops the haystack in progress.
    add_row(OP_HAYSTACK, 16'h0061, 1, 0, 0, ST_NOT_FOUND, 0);
    add_row(OP_NEEDLE, 16'h0063, 1, 1, 0, ST_NOT_FOUND, 0);
    add_row(OP_HAYSTACK, 16'h0063, 1, 1, 1, ST_FOUND, 0);
    // Needle overflow.
    add_row(OP_NEEDLE, 16'h0041, NEEDLE_MAX + 1, 1, 0, ST_NOT_FOUND, 0);
    add_row(OP_HAYSTACK, 16'h0041, 4, 1, 1, ST_TOO_LONG, 0);
    // Full-size needle matched on the last haystack character.
    add_row(OP_NEEDLE, 16'h005A, NEEDLE_MAX - 1, 0, 0, ST_NOT_FOUND, 0);
    add_row(OP_NEEDLE, 16'h0051, 1, 1, 0, ST_NOT_FOUND, 0);
    add_row(OP_HAYSTACK, 16'h005A, NEEDLE_MAX - 1, 0, 0, ST_NOT_FOUND, 0);
    add_row(OP_HAYSTACK, 16'h0051, 1, 1, 1, ST_FOUND, 0);

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        offer_item(dir_rows[r].op, dir_rows[r].ch,
                   dir_rows[r].last && (k == dir_rows[r].reps - 1),
                   dir_rows[r].pinned, '{dir_rows[r].st, dir_rows[r].start});
      end
    end

    // Random phases alternate the mode and vary how much each side idles.
    for (int ph = 0; ph < 6; ph++) begin
      set_case_fold(ph % 2 == 0);
      case (ph)
        0: begin gap_pct = 20; rx_pct = 20; end
        1: begin gap_pct = 0;  rx_pct = 0;  end
        2: begin gap_pct = 50; rx_pct = 50; end
        3: begin gap_pct = 5;  rx_pct = 40; end
        4: begin gap_pct = 30; rx_pct = 0;  end
        default: begin gap_pct = 15; rx_pct = 15; end
      endcase
      if (ph == 3) begin
        overfill_results();
        gap_pct = 5;
      end
      target = useful_items + 66;
      while (useful_items < target) begin
        random_search();
      end
      random_items += 66;
    end

    rx_pct = 0;
    settle();
    repeat (50) @(posedge clk);

    $display("Run covered %0d items (about %0d random) over %0d mode writes.",
             useful_items, random_items, mode_writes);
    $display("Results checked: %0d found, %0d not found, %0d needle too long.",
             found_count, miss_count, overlong_count);
    if (err_count == 0) begin
      $display("utf16_substring_finder verification clean");
    end else begin
      $display("utf16_substring_finder verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/usf_pkg.sv
rtl/core/usf_cell.sv
rtl/core/usf_out_buf.sv
rtl/core/utf16_substring_finder.sv
sim/utf16_substring_finder_tb.sv
